### rtl/splc_pkg.sv
package splc_pkg;

   localparam int NUM_POINTS_W = 11;
   localparam logic [NUM_POINTS_W-1:0] NUM_POINTS_RESET = 11'd1001;

   localparam int DEF_MAX_POINTS = 1024;
   localparam int DEF_FRAC_BITS = 16;

   localparam int STRAIN_W = 32;
   localparam int INDEX_W = 10;
   localparam int DISP_W = 31;
   localparam int FORCE_W = 31;
   localparam int SLOPE_W = 32;
   localparam int STRESS_W = 32;
   localparam int SEGMENT_W = 10;

   localparam logic OP_EVALUATE = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   localparam logic [STRESS_W-1:0] STRESS_MAX = 32'h7FFF_FFFF;
   localparam logic [STRESS_W-1:0] STRESS_MIN = 32'h8000_0000;

   typedef struct packed {
      logic opcode;
      logic signed [STRAIN_W-1:0] strain;
      logic [INDEX_W-1:0] entry_index;
      logic [DISP_W-1:0] entry_disp;
      logic [FORCE_W-1:0] entry_force;
      logic signed [SLOPE_W-1:0] entry_slope;
   } splc_req_type;

   typedef struct packed {
      logic signed [STRESS_W-1:0] stress;
      logic signed [SLOPE_W-1:0] tangent;
      logic [SEGMENT_W-1:0] segment;
      logic extrapolated;
   } splc_rsp_type;

   typedef struct packed {
      logic capture;
      logic write_entry;
      logic start_scan;
      logic step;
      logic select_zero;
      logic select_seg;
      logic commit;
      logic out_load;
   } splc_cmd_type;

   typedef struct packed {
      logic same_strain;
      logic in_zero;
      logic beyond;
      logic last_entry;
   } splc_sts_type;

endpackage

### rtl/splc_ctrl.sv
module splc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_opcode,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  splc_pkg::splc_sts_type sts,
   output splc_pkg::splc_cmd_type cmd
);
   import splc_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ZERO  = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_MUL   = 3'd3;
   localparam logic [2:0] ST_SCALE = 3'd4;
   localparam logic [2:0] ST_SUM   = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_opcode == OP_LOAD) begin
                  cmd.write_entry = 1'b1;
               end else begin
                  cmd.capture = 1'b1;
                  state_in    = sts.same_strain ? ST_DONE : ST_ZERO;
               end
            end
         end
         ST_ZERO: begin
            if (sts.in_zero) begin
               cmd.select_zero = 1'b1;
               state_in        = ST_MUL;
            end else begin
               cmd.start_scan = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.beyond && !sts.last_entry) begin
               cmd.step = 1'b1;
            end else begin
               cmd.select_seg = 1'b1;
               state_in       = ST_MUL;
            end
         end
         ST_MUL:   state_in = ST_SCALE;
         ST_SCALE: state_in = ST_SUM;
         ST_SUM: begin
            cmd.commit = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_out_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("result register not valid after a load");

   a_scan_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> ($past(state_ff) == ST_ZERO || $past(state_ff) == ST_SCAN))
      else $error("scan entered from an unexpected state");

   a_new_strain_searches: assert property (@(posedge clock) disable iff (reset)
      (accept && req_opcode == OP_EVALUATE && !sts.same_strain) |=> (state_ff == ST_ZERO))
      else $error("new strain did not start a search");

endmodule

### rtl/splc_dp.sv
module splc_dp #(
   parameter int MAX_POINTS = splc_pkg::DEF_MAX_POINTS,
   parameter int FRAC_BITS  = splc_pkg::DEF_FRAC_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  splc_pkg::splc_req_type               req_payload,
   input  logic                                 csr_write_enable,
   input  logic [splc_pkg::NUM_POINTS_W-1:0]    csr_write_data,
   input  splc_pkg::splc_cmd_type               cmd,
   output splc_pkg::splc_sts_type               sts,
   output splc_pkg::splc_rsp_type               rsp_payload
);
   import splc_pkg::*;

   localparam int IDX_W  = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
   localparam int NW     = (IDX_W + 1 > NUM_POINTS_W) ? IDX_W + 1 : NUM_POINTS_W;
   localparam int OFF_W  = STRAIN_W + 1;
   localparam int PROD_W = OFF_W + SLOPE_W;
   localparam int SUM_W  = PROD_W + 1;
   localparam logic [PROD_W-1:0] FRAC_MASK = (PROD_W'(1) << FRAC_BITS) - PROD_W'(1);

   typedef struct packed {
      logic [DISP_W-1:0]          bp_disp;
      logic [FORCE_W-1:0]         bp_force;
      logic signed [SLOPE_W-1:0]  bp_slope;
   } splc_entry_type;

   splc_entry_type mem [MAX_POINTS];
   splc_entry_type rd_data_ff;

   logic [NUM_POINTS_W-1:0]    num_points_ff, num_points_in;
   logic [NW-1:0]              num_wide, n_eff;
   logic [NW-1:0]              idx_wide, k_next_wide, k_wide, seg_wide;
   logic [IDX_W-1:0]           wr_addr, rd_addr, k_next;
   logic                       wr_en, load_zero;

   logic [IDX_W-1:0]           k_ff, k_in;
   logic                       neg_ff, neg_in;
   logic signed [STRAIN_W-1:0] strain_ff, strain_in;

   logic signed [OFF_W-1:0]    s_ext, d_ext, offset_in;
   logic signed [STRESS_W-1:0] f_ext, base_in;
   logic                       use_neg;

   logic signed [OFF_W-1:0]    offset_ff;
   logic signed [STRESS_W-1:0] base_ff;
   logic signed [SLOPE_W-1:0]  slope_ff;
   logic [IDX_W-1:0]           sel_k_ff;
   logic                       ext_ff;

   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic [PROD_W-1:0]          round_add;
   logic signed [PROD_W-1:0]   biased, scaled_ff, scaled_in;
   logic signed [SUM_W-1:0]    sum_wide;
   logic [STRESS_W-1:0]        stress_sat;
   logic                       sum_ovf;

   logic signed [STRAIN_W-1:0] last_strain_ff, last_strain_in;
   logic signed [STRESS_W-1:0] last_stress_ff, last_stress_in;
   logic signed [SLOPE_W-1:0]  last_tangent_ff, last_tangent_in;
   logic [SEGMENT_W-1:0]       last_segment_ff, last_segment_in;
   logic                       last_extrap_ff, last_extrap_in;

   splc_rsp_type               out_ff, out_in;

   // Point count in effect, held to the range the scan supports.
   assign num_points_in = csr_write_enable ? csr_write_data : num_points_ff;
   assign num_wide      = NW'(num_points_ff);

   always_comb begin
      priority if (num_wide < NW'(2)) begin
         n_eff = NW'(2);
      end else if (num_wide > NW'(MAX_POINTS)) begin
         n_eff = NW'(MAX_POINTS);
      end else begin
         n_eff = num_wide;
      end
   end

   // Table memory: one write port for loads, one registered read port for the scan.
   assign idx_wide  = NW'(req_payload.entry_index);
   assign wr_en     = cmd.write_entry && (idx_wide < NW'(MAX_POINTS));
   assign wr_addr   = idx_wide[IDX_W-1:0];
   assign load_zero = wr_en && (idx_wide == '0);

   assign k_next_wide = NW'(k_ff) + NW'(1);
   assign k_next      = k_next_wide[IDX_W-1:0];

   always_comb begin
      priority if (cmd.start_scan) begin
         rd_addr = IDX_W'(1);
      end else if (cmd.step) begin
         rd_addr = k_next;
      end else begin
         rd_addr = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= '{bp_disp:  req_payload.entry_disp,
                           bp_force: req_payload.entry_force,
                           bp_slope: req_payload.entry_slope};
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Search state.
   assign strain_in = cmd.capture ? req_payload.strain : strain_ff;
   assign s_ext     = OFF_W'(strain_ff);
   assign d_ext     = $signed({2'b00, rd_data_ff.bp_disp});

   always_comb begin
      k_in   = k_ff;
      neg_in = neg_ff;
      if (cmd.start_scan) begin
         k_in   = IDX_W'(1);
         neg_in = (s_ext < -d_ext);
      end else if (cmd.step) begin
         k_in = k_next;
      end
   end

   assign sts.same_strain = (req_payload.strain == last_strain_ff);
   assign sts.in_zero     = (s_ext >= -d_ext) && (s_ext <= d_ext);
   assign sts.beyond      = neg_ff ? (s_ext < -d_ext) : (s_ext > d_ext);
   assign sts.last_entry  = (k_next_wide >= n_eff);

   // Operands of the selected segment.
   assign use_neg   = cmd.select_zero || neg_ff;
   assign offset_in = use_neg ? (s_ext + d_ext) : (s_ext - d_ext);
   assign f_ext     = $signed({1'b0, rd_data_ff.bp_force});
   assign base_in   = use_neg ? -f_ext : f_ext;

   // Multiply, then truncate toward zero, then add and saturate.
   assign prod_in   = PROD_W'(offset_ff) * PROD_W'(slope_ff);
   assign round_add = prod_ff[PROD_W-1] ? FRAC_MASK : '0;
   assign biased    = prod_ff + $signed(round_add);
   assign scaled_in = biased >>> FRAC_BITS;
   assign sum_wide  = SUM_W'(base_ff) + SUM_W'(scaled_ff);
   assign sum_ovf   = !((&sum_wide[SUM_W-1:STRESS_W-1]) || !(|sum_wide[SUM_W-1:STRESS_W-1]));

   always_comb begin
      if (sum_ovf) begin
         stress_sat = sum_wide[SUM_W-1] ? STRESS_MIN : STRESS_MAX;
      end else begin
         stress_sat = sum_wide[STRESS_W-1:0];
      end
   end

   assign k_wide   = NW'(k_ff);
   assign seg_wide = NW'(sel_k_ff);

   always_comb begin
      last_strain_in  = last_strain_ff;
      last_stress_in  = last_stress_ff;
      last_tangent_in = last_tangent_ff;
      last_segment_in = last_segment_ff;
      last_extrap_in  = last_extrap_ff;
      if (load_zero) begin
         last_strain_in  = '0;
         last_stress_in  = '0;
         last_tangent_in = req_payload.entry_slope;
         last_segment_in = '0;
         last_extrap_in  = 1'b0;
      end else if (cmd.commit) begin
         last_strain_in  = strain_ff;
         last_stress_in  = stress_sat;
         last_tangent_in = slope_ff;
         last_segment_in = seg_wide[SEGMENT_W-1:0];
         last_extrap_in  = ext_ff;
      end
   end

   always_comb begin
      out_in = out_ff;
      if (cmd.out_load) begin
         out_in = '{stress: last_stress_ff, tangent: last_tangent_ff,
                    segment: last_segment_ff, extrapolated: last_extrap_ff};
      end
   end

   assign rsp_payload = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_points_ff   <= NUM_POINTS_RESET;
         last_strain_ff  <= '0;
         last_stress_ff  <= '0;
         last_tangent_ff <= '0;
         last_segment_ff <= '0;
         last_extrap_ff  <= 1'b0;
      end else begin
         num_points_ff   <= num_points_in;
         last_strain_ff  <= last_strain_in;
         last_stress_ff  <= last_stress_in;
         last_tangent_ff <= last_tangent_in;
         last_segment_ff <= last_segment_in;
         last_extrap_ff  <= last_extrap_in;
      end
   end

   always_ff @(posedge clock) begin
      strain_ff <= strain_in;
      k_ff      <= k_in;
      neg_ff    <= neg_in;
      prod_ff   <= prod_in;
      scaled_ff <= scaled_in;
      out_ff    <= out_in;
      if (cmd.select_zero || cmd.select_seg) begin
         offset_ff <= offset_in;
         base_ff   <= base_in;
         slope_ff  <= rd_data_ff.bp_slope;
         sel_k_ff  <= cmd.select_zero ? '0 : k_ff;
         ext_ff    <= cmd.select_seg && sts.beyond;
      end
   end

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.step |=> (k_wide < n_eff))
      else $error("scan index ran past the points in use");

endmodule

### rtl/symmetric_piecewise_linear_curve.sv
// Odd-symmetric piecewise-linear curve evaluator in Q16.16. A load transaction
// (opcode 1) writes one table entry of breakpoint displacement, force and
// segment slope; loading entry 0 also resets the stored operating point to
// zero strain and stress. An evaluate transaction (opcode 0) returns stress,
// tangent, segment and an extrapolation flag. A strain equal to the previous
// one returns the stored result without a search, and a strain inside segment
// 0 skips the search. Otherwise the segment is found by a linear search, which
// reads one entry a cycle through the single read port of the table memory
// over at most n entries, where n is num_points held to the range 2 through
// MAX_POINTS, followed by a multiply, truncate and saturate pipeline. Entries
// must be loaded before they are searched. csr_write_data sets the number of
// entries in use.
module symmetric_piecewise_linear_curve #(
   parameter int MAX_POINTS = splc_pkg::DEF_MAX_POINTS,
   parameter int FRAC_BITS  = splc_pkg::DEF_FRAC_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  splc_pkg::splc_req_type            req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output splc_pkg::splc_rsp_type            rsp_payload,
   input  logic                              csr_write_enable,
   input  logic [splc_pkg::NUM_POINTS_W-1:0] csr_write_data
);
   import splc_pkg::*;

   splc_cmd_type cmd;
   splc_sts_type sts;

   // The controller sequences each transaction: it takes new transactions
   // only while idle, steps the search, and hands the result to the output
   // register, which may still hold an earlier result while the next
   // transaction is taken.
   splc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_payload.opcode),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .sts        (sts),
      .cmd        (cmd)
   );

   // The datapath holds the table memory, the point-count register, the
   // stored operating point and the arithmetic pipeline.
   splc_dp #(
      .MAX_POINTS (MAX_POINTS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_payload      (rsp_payload)
   );

endmodule
